/* design/gfba_pkg.sv */
package gfba_pkg;

  localparam int GROUP_SIZE  = 100;
  localparam int BLOCK_COUNT = 1024;

  localparam int GROUP_WORDS = GROUP_SIZE + 1;
  localparam int STORE_DEPTH = BLOCK_COUNT * GROUP_WORDS;

  localparam int NUM_W    = 10;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(GROUP_SIZE + 1);
  localparam int STACK_AW = $clog2(GROUP_SIZE);
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED    = 2'd2;

  typedef struct packed {
    logic                stack_we;
    logic [STACK_AW-1:0] stack_waddr;
    logic [NUM_W-1:0]    stack_wdata;
    logic [STACK_AW-1:0] stack_raddr;
    logic                group_we;
    logic [STORE_AW-1:0] group_waddr;
    logic [NUM_W-1:0]    group_wdata;
    logic [STORE_AW-1:0] group_raddr;
  } mem_req_t;

  typedef struct packed {
    logic                load;
    logic [NUM_W-1:0]    granted_block;
    logic [STATUS_W-1:0] status;
  } result_t;

  // first word of the group kept under a block
  function automatic logic [STORE_AW-1:0] group_base(input logic [NUM_W-1:0] num);
    return STORE_AW'((32'(num) % BLOCK_COUNT) * GROUP_WORDS);
  endfunction

endpackage

/* design/gfba_ifs.sv */
interface gfba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [gfba_pkg::NUM_W-1:0]   block_number;

  modport source (output valid, output cmd, output block_number, input ready);
  modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

interface gfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gfba_pkg::NUM_W-1:0]    granted_block;
  logic [gfba_pkg::STATUS_W-1:0] status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink   (input valid, input granted_block, input status, output ready);
endinterface

/* design/grouped_free_block_allocator.sv */
// Grouped free block allocator: a stack of free block numbers backed by a
// store of spilled groups, one group under each block number.
// req carries one transaction per command: cmd free pushes block_number,
// cmd alloc pops a block (block_number is ignored). rsp returns exactly one
// transaction per command with granted_block and status.
// A plain push or pop passes through S_FREE or S_ALLOC and then S_RESP; an
// alloc on an empty stack goes straight to S_RESP, and a free on an empty stack
// pushes the sentinel first. A free on a full stack spills the count and
// the whole stack into the group store, one word a cycle through the store
// write port. An alloc that pops the last entry refills the stack from that
// block's group one word a cycle through the store read port.
// req.ready is high only while the sequencer is idle, so one command is in
// work at a time; the next command is taken the cycle after the result
// moves into the output register.
// Reset (rst, synchronous) empties the stack; stack and group contents are
// not cleared. If rsp.ready is low the result waits in the output register
// and the next command may still be taken and worked up to its own result.
module grouped_free_block_allocator (
  input  logic       clk,
  input  logic       rst,
  gfba_req_if.sink   req,
  gfba_rsp_if.source rsp
);

  gfba_pkg::mem_req_t            mem;
  gfba_pkg::result_t             res;
  logic [gfba_pkg::NUM_W-1:0]    stack_rdata;
  logic [gfba_pkg::NUM_W-1:0]    group_rdata;
  logic                          out_free;

  assign out_free = !rsp.valid || rsp.ready;

  gfba_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .out_free    (out_free),
    .stack_rdata (stack_rdata),
    .group_rdata (group_rdata),
    .mem         (mem),
    .res         (res)
  );

  gfba_ram #(
    .WIDTH (gfba_pkg::NUM_W),
    .DEPTH (gfba_pkg::GROUP_SIZE)
  ) u_stack (
    .clk   (clk),
    .we    (mem.stack_we),
    .waddr (mem.stack_waddr),
    .wdata (mem.stack_wdata),
    .raddr (mem.stack_raddr),
    .rdata (stack_rdata)
  );

  gfba_ram #(
    .WIDTH (gfba_pkg::NUM_W),
    .DEPTH (gfba_pkg::STORE_DEPTH)
  ) u_group (
    .clk   (clk),
    .we    (mem.group_we),
    .waddr (mem.group_waddr),
    .wdata (mem.group_wdata),
    .raddr (mem.group_raddr),
    .rdata (group_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res.load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (res.load) begin
      rsp.granted_block <= res.granted_block;
      rsp.status        <= res.status;
    end
  end

endmodule

/* design/gfba_ram.sv */
module gfba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/gfba_ctrl.sv */
module gfba_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  gfba_req_if.sink                    req,
  input  logic                        out_free,
  input  logic [gfba_pkg::NUM_W-1:0]  stack_rdata,
  input  logic [gfba_pkg::NUM_W-1:0]  group_rdata,
  output gfba_pkg::mem_req_t          mem,
  output gfba_pkg::result_t           res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FREE    = 3'd1;
  localparam logic [2:0] S_SPILL   = 3'd2;
  localparam logic [2:0] S_ALLOC   = 3'd3;
  localparam logic [2:0] S_REF_CNT = 3'd4;
  localparam logic [2:0] S_REFILL  = 3'd5;
  localparam logic [2:0] S_RESP    = 3'd6;

  localparam int CW = gfba_pkg::CNT_W;
  localparam int SA = gfba_pkg::STACK_AW;
  localparam int NW = gfba_pkg::NUM_W;
  localparam logic [SA-1:0] IDX_LAST = SA'(gfba_pkg::GROUP_SIZE - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(gfba_pkg::GROUP_SIZE);

  logic [2:0]                      state, state_next;
  logic [CW-1:0]                   count, count_next;
  logic [SA-1:0]                   idx, idx_next;
  logic [gfba_pkg::STORE_AW-1:0]   gaddr, gaddr_next;
  logic [NW-1:0]                   blk, blk_next;
  logic [NW-1:0]                   res_block, res_block_next;
  logic [gfba_pkg::STATUS_W-1:0]   res_status, res_status_next;
  logic [CW-1:0]                   cnt_dec;
  logic [gfba_pkg::STORE_AW-1:0]   base;

  assign req.ready = (state == S_IDLE);
  assign cnt_dec   = count - CW'(1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    gaddr_next      = gaddr;
    blk_next        = blk;
    res_block_next  = res_block;
    res_status_next = res_status;
    base            = gfba_pkg::group_base(blk);
    mem             = '0;
    mem.stack_raddr = cnt_dec[SA-1:0];
    res.load          = 1'b0;
    res.granted_block = res_block;
    res.status        = res_status;

    unique case (state)
      S_IDLE: begin
        // stack top read is issued here so an alloc sees it next cycle
        if (req.valid) begin
          blk_next = req.block_number;
          if (req.cmd == gfba_pkg::CMD_FREE) begin
            state_next = S_FREE;
          end else if (count == '0) begin
            res_block_next  = '0;
            res_status_next = gfba_pkg::ST_NO_SPACE;
            state_next      = S_RESP;
          end else begin
            state_next = S_ALLOC;
          end
        end
      end
      S_FREE: begin
        if (count == '0) begin
          // end-of-list sentinel
          mem.stack_we    = 1'b1;
          mem.stack_waddr = '0;
          mem.stack_wdata = '0;
          count_next      = CW'(1);
        end else if (count >= CNT_FULL) begin
          mem.group_we    = 1'b1;
          mem.group_waddr = base;
          mem.group_wdata = NW'(count);
          mem.stack_raddr = '0;
          gaddr_next      = base + gfba_pkg::STORE_AW'(1);
          idx_next        = '0;
          state_next      = S_SPILL;
        end else begin
          mem.stack_we    = 1'b1;
          mem.stack_waddr = count[SA-1:0];
          mem.stack_wdata = blk;
          count_next      = count + CW'(1);
          res_block_next  = '0;
          res_status_next = gfba_pkg::ST_FREED;
          state_next      = S_RESP;
        end
      end
      S_SPILL: begin
        mem.group_we    = 1'b1;
        mem.group_waddr = gaddr;
        mem.group_wdata = stack_rdata;
        mem.stack_raddr = idx + SA'(1);
        gaddr_next      = gaddr + gfba_pkg::STORE_AW'(1);
        idx_next        = idx + SA'(1);
        if (idx == IDX_LAST) begin
          // stack is empty now, the freed block goes to the bottom
          mem.stack_we    = 1'b1;
          mem.stack_waddr = '0;
          mem.stack_wdata = blk;
          count_next      = CW'(1);
          res_block_next  = '0;
          res_status_next = gfba_pkg::ST_FREED;
          state_next      = S_RESP;
        end
      end
      S_ALLOC: begin
        if (stack_rdata == '0) begin
          count_next      = '0;
          res_block_next  = '0;
          res_status_next = gfba_pkg::ST_NO_SPACE;
          state_next      = S_RESP;
        end else begin
          res_block_next  = stack_rdata;
          res_status_next = gfba_pkg::ST_GRANTED;
          count_next      = cnt_dec;
          if (cnt_dec == '0) begin
            mem.group_raddr = gfba_pkg::group_base(stack_rdata);
            gaddr_next      = gfba_pkg::group_base(stack_rdata) + gfba_pkg::STORE_AW'(1);
            state_next      = S_REF_CNT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_REF_CNT: begin
        if (group_rdata > NW'(gfba_pkg::GROUP_SIZE)) begin
          count_next = CNT_FULL;
        end else begin
          count_next = group_rdata[CW-1:0];
        end
        mem.group_raddr = gaddr;
        gaddr_next      = gaddr + gfba_pkg::STORE_AW'(1);
        idx_next        = '0;
        state_next      = S_REFILL;
      end
      S_REFILL: begin
        mem.stack_we    = 1'b1;
        mem.stack_waddr = idx;
        mem.stack_wdata = group_rdata;
        mem.group_raddr = gaddr;
        gaddr_next      = gaddr + gfba_pkg::STORE_AW'(1);
        idx_next        = idx + SA'(1);
        if (idx == IDX_LAST) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          res.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx        <= idx_next;
    gaddr      <= gaddr_next;
    blk        <= blk_next;
    res_block  <= res_block_next;
    res_status <= res_status_next;
  end

endmodule

/* tb/gfba_checker.sv */
module gfba_checker
  import gfba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  gfba_req_if        req,
  gfba_rsp_if        rsp,
  output int         errors,
  output int         outstanding,
  output int         n_granted,
  output int         n_empty,
  output int         n_spill,
  output int         n_refill
);

  typedef struct packed {
    logic [NUM_W-1:0]    granted_block;
    logic [STATUS_W-1:0] status;
  } alloc_rsp_t;

  logic [NUM_W-1:0] free_list [GROUP_SIZE];
  int unsigned      list_fill;
  logic [NUM_W-1:0] spill_store [BLOCK_COUNT][GROUP_WORDS];
  alloc_rsp_t       owed_rsp [$];

  function automatic alloc_rsp_t allocator_step(input logic cmd, input logic [NUM_W-1:0] num);
    alloc_rsp_t  r;
    logic [NUM_W-1:0] got;
    int unsigned base;
    int unsigned n;
    r.granted_block = '0;
    if (cmd == CMD_FREE) begin
      // empty list: the end-of-list marker goes in first
      if (list_fill == 0) begin
        free_list[0] = '0;
        list_fill = 1;
      end
      if (list_fill >= GROUP_SIZE) begin
        base = int'(num) % BLOCK_COUNT;
        spill_store[base][0] = NUM_W'(list_fill);
        for (int i = 0; i < GROUP_SIZE; i++) spill_store[base][i+1] = free_list[i];
        list_fill = 0;
        n_spill++;
      end
      free_list[list_fill] = num;
      list_fill++;
      r.status = ST_FREED;
      return r;
    end
    r.status = ST_NO_SPACE;
    if (list_fill == 0) begin
      n_empty++;
      return r;
    end
    list_fill--;
    got = free_list[list_fill];
    // a zero popped is the end marker and drops the whole list
    if (got == '0) begin
      list_fill = 0;
      n_empty++;
      return r;
    end
    if (list_fill == 0) begin
      base = int'(got) % BLOCK_COUNT;
      n = spill_store[base][0];
      if (n > GROUP_SIZE) n = GROUP_SIZE;
      for (int i = 0; i < GROUP_SIZE; i++) free_list[i] = spill_store[base][i+1];
      list_fill = n;
      n_refill++;
    end
    n_granted++;
    r.granted_block = got;
    r.status = ST_GRANTED;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (rst) begin
      list_fill = 0;
      owed_rsp.delete();
    end else begin
      // check before predicting so a response never meets its own command
      if (rsp.valid && rsp.ready) begin
        if (owed_rsp.size() == 0) begin
          $display("%0t: response transaction with nothing expected (granted_block %0d status %0d)",
                   $time, rsp.granted_block, rsp.status);
          errors++;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.granted_block !== want.granted_block) begin
            $display("%0t: granted_block expected %0d actual %0d",
                     $time, want.granted_block, rsp.granted_block);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) owed_rsp.push_back(allocator_step(req.cmd, req.block_number));
    end
    outstanding <= owed_rsp.size();
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  import gfba_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   quiet_cycles;
  int   errors;
  int   outstanding;
  int   n_granted;
  int   n_empty;
  int   n_spill;
  int   n_refill;

  gfba_req_if req ();
  gfba_rsp_if rsp ();

  grouped_free_block_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  gfba_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding),
    .n_granted   (n_granted),
    .n_empty     (n_empty),
    .n_spill     (n_spill),
    .n_refill    (n_refill)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // nothing moving on either channel for too long means a hang
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic cmd, input logic [NUM_W-1:0] num);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.cmd          <= cmd;
    req.block_number <= num;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] pick_block();
    int r;
    r = $urandom_range(199);
    if (r == 0) return '0;
    if (r < 6) return '1;
    return NUM_W'($urandom_range(1, 1023));
  endfunction

  // mostly one kind of command, with the other mixed in as noise
  task automatic run_burst(input int count, input int free_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < free_pct) send_cmd(CMD_FREE, pick_block());
      else send_cmd(CMD_ALLOC, NUM_W'($urandom_range(1023)));
    end
  endtask

  initial begin
    int grow_len [3];
    int drain_len [3];
    grow_len  = '{150, 120, 80};
    drain_len = '{50, 80, 120};
    src_idle_pct = 26;
    snk_idle_pct = 54;
    req.valid        <= 1'b0;
    req.cmd          <= CMD_ALLOC;
    req.block_number <= '0;
    rst              <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty list, end marker, freed zero, extreme numbers
    send_cmd(CMD_ALLOC, '1);
    send_cmd(CMD_FREE, '0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, 10'h2AA);
    send_cmd(CMD_FREE, '1);
    send_cmd(CMD_FREE, 10'd1);
    send_cmd(CMD_FREE, 10'h2AA);
    send_cmd(CMD_FREE, 10'h155);
    send_cmd(CMD_ALLOC, 10'h155);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '1);
    send_cmd(CMD_ALLOC, 10'd7);
    send_cmd(CMD_ALLOC, 10'd7);
    send_cmd(CMD_ALLOC, 10'd7);
    send_cmd(CMD_FREE, 10'd512);
    send_cmd(CMD_FREE, '0);
    send_cmd(CMD_FREE, 10'd3);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_ALLOC, 10'd0);

    // each phase grows past a spill and then drains back through a refill
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 26;
          snk_idle_pct = 54;
        end
        1: begin
          src_idle_pct = 54;
          snk_idle_pct = 26;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      run_burst(grow_len[ph], 95);
      run_burst(drain_len[ph], 5);
    end
    req.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d grants and %0d no-space answers", n_granted, n_empty);
    $display("with %0d group spills and %0d group refills", n_spill, n_refill);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
